// File: rtl/core/grid_line_of_sight_walk_assert.svh
// Assertion macros used by the checker file
`ifndef GRID_LINE_OF_SIGHT_WALK_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_WALK_ASSERT_SVH

// Same-cycle implication, held off during reset
`define GLOS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glos assertion failed");

// Next-cycle implication, held off during reset
`define GLOS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glos assertion failed");

`endif

// File: rtl/core/glos_pkg.sv
package glos_pkg;

  // Stream widths, whole bytes
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 16;

  // Input item field offsets in s_axis_tdata
  localparam int CELL_X_LO    = 0;
  localparam int CELL_Y_LO    = 8;
  localparam int CELL_OPEN_LO = 16;
  localparam int START_X_LO   = 17;
  localparam int START_Y_LO   = 33;
  localparam int END_X_LO     = 49;
  localparam int END_Y_LO     = 65;

  // Coordinate and count widths
  localparam int COORD_W = 16;
  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  // Shared multiply-accumulate operand width
  localparam int OPW = 17;

  // Item kinds carried in tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;   // update accumulator
    logic clr;  // start from zero
    logic sub;  // subtract product rather than add
  } mac_ctrl_t;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_WR_RD = 8'b0000_0100,
    ST_WR_WB = 8'b0000_1000,
    ST_MUL1  = 8'b0001_0000,
    ST_MUL2  = 8'b0010_0000,
    ST_WALK  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

endpackage

// File: rtl/core/glos_map.sv
// Passability map, one row of cells per word
module glos_map #(
  parameter int SIDE_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [SIDE_BITS-1:0]     rd_row,
  output logic [(1<<SIDE_BITS)-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [SIDE_BITS-1:0]     wr_row,
  input  logic [(1<<SIDE_BITS)-1:0] wr_data
);

  localparam int SIDE = 1 << SIDE_BITS;

  logic [SIDE-1:0] mem [SIDE];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

// File: rtl/core/glos_mac.sv
// Shared multiply-accumulate unit: error term set-up and walk updates
module glos_mac #(
  parameter int ACC_W = 28
) (
  input  logic                    clk,
  input  glos_pkg::mac_ctrl_t     ctrl,
  input  logic [glos_pkg::OPW-1:0] op_a,
  input  logic [glos_pkg::OPW-1:0] op_b,
  output logic signed [ACC_W-1:0] acc
);

  import glos_pkg::*;

  logic [2*OPW-1:0]       prod;
  logic [ACC_W+2*OPW-1:0] prod_ext;
  logic [ACC_W-1:0]       prod_w;
  logic [ACC_W-1:0]       base;
  logic [ACC_W-1:0]       acc_next;

  // Product, sized to the accumulator
  assign prod     = op_a * op_b;
  assign prod_ext = {{ACC_W{1'b0}}, prod};
  assign prod_w   = prod_ext[ACC_W-1:0];

  always_comb begin
    base     = ctrl.clr ? '0 : acc;
    acc_next = ctrl.sub ? base - prod_w : base + prod_w;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= acc_next;
    end
  end

endmodule

// File: rtl/core/grid_line_of_sight_walk.sv
// Channel  Dir  Signals             Contents
// s_axis   in   tvalid/tready/data  write cell or line-of-sight query; tuser = mode
// m_axis   out  tvalid/tready/data  one result item per input item
//
// A write item passes through a row read and a row write-back before its result.
// A query runs two set-up multiplies of the shared unit, one map read per cell crossed
//   (at most 2^(18-FRAC_BITS) - 1), then the result.
// After reset a clearing pass writes every map row to blocked with s_axis_tready low.
// One item at a time; the next is accepted as soon as the result sits in the
//   output register, even if m_axis_tready is low.
module grid_line_of_sight_walk #(
  parameter int MAP_SIDE_BITS = 8,
  parameter int FRAC_BITS     = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // cell_x, cell_y, cell_open, start_x, start_y, end_x, end_y
  input  logic [glos_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // line_clear, cells_examined
  output logic [glos_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  import glos_pkg::*;

  localparam int MSB  = MAP_SIDE_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int SIDE = 1 << MSB;
  localparam int CB   = 17 - FB;        // cell index width
  localparam int CW   = CB + 3;         // signed walk coordinate
  localparam int SW   = CB + 2;         // cells still to visit
  localparam int EW   = FB + 20;        // error term
  localparam int XW   = CW + MSB + 1;   // bounds compare
  localparam logic [OPW-1:0] ONE = OPW'(1) << FB;

  state_t state;

  // Input item fields
  logic [7:0]         in_cell_x, in_cell_y;
  logic               in_cell_open;
  logic [COORD_W-1:0] x0, y0, x1, y1;
  logic               acc_in;

  assign in_cell_x    = s_axis_tdata[CELL_X_LO +: 8];
  assign in_cell_y    = s_axis_tdata[CELL_Y_LO +: 8];
  assign in_cell_open = s_axis_tdata[CELL_OPEN_LO];
  assign x0           = s_axis_tdata[START_X_LO +: COORD_W];
  assign y0           = s_axis_tdata[START_Y_LO +: COORD_W];
  assign x1           = s_axis_tdata[END_X_LO +: COORD_W];
  assign y1           = s_axis_tdata[END_Y_LO +: COORD_W];
  assign acc_in       = s_axis_tvalid && s_axis_tready;

  // Query set-up, worked out from the item as it is accepted
  logic               q_xpos, q_ypos;
  logic [COORD_W-1:0] q_dx, q_dy;
  logic [CB-1:0]      cx0, cy0, cx1, cy1, span_x, span_y;
  logic [OPW-1:0]     q_fxa, q_fya;
  logic [SW-1:0]      q_steps;

  always_comb begin
    q_xpos = x1 > x0;
    q_ypos = y1 > y0;
    q_dx   = q_xpos ? x1 - x0 : x0 - x1;
    q_dy   = q_ypos ? y1 - y0 : y0 - y1;
    cx0    = CB'(x0 >> FB);
    cy0    = CB'(y0 >> FB);
    cx1    = CB'(x1 >> FB);
    cy1    = CB'(y1 >> FB);
    span_x = q_xpos ? cx1 - cx0 : cx0 - cx1;
    span_y = q_ypos ? cy1 - cy0 : cy0 - cy1;
    q_fxa  = q_xpos ? ONE - OPW'(x0[FB-1:0]) : OPW'(x0[FB-1:0]);
    q_fya  = q_ypos ? ONE - OPW'(y0[FB-1:0]) : OPW'(y0[FB-1:0]);
    q_steps = SW'(1) + SW'(span_x) + SW'(span_y);
  end

  // Write cell, taken modulo the map side
  logic [MSB+7:0] wx_ext, wy_ext;
  assign wx_ext = (MSB+8)'(in_cell_x);
  assign wy_ext = (MSB+8)'(in_cell_y);

  // Working registers
  logic [COORD_W-1:0]   dx, dy;
  logic [OPW-1:0]       fxa, fya;
  logic                 xpos, ypos;
  logic signed [CW-1:0] walk_x, walk_y;
  logic [SW-1:0]        steps_left;
  logic [MSB-1:0]       wr_col, wr_row_q;
  logic                 wr_open;
  logic [MSB-1:0]       clr_row;
  logic                 pend_valid, pend_inb, pend_last;
  logic [MSB-1:0]       pend_col;
  logic [COUNT_W-1:0]   cnt;
  logic                 res_clear;

  // Shared unit
  mac_ctrl_t            mac_ctrl;
  logic [OPW-1:0]       mac_a, mac_b;
  logic signed [EW-1:0] walk_error;
  logic                 err_pos;

  assign err_pos = walk_error > 0;

  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    unique case (state)
      ST_MUL1: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a    = fxa;
        mac_b    = OPW'(dy);
      end
      ST_MUL2: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        mac_a    = fya;
        mac_b    = OPW'(dx);
      end
      ST_WALK: begin
        mac_ctrl = '{en: steps_left != '0, clr: 1'b0, sub: err_pos};
        mac_a    = err_pos ? OPW'(dx) : OPW'(dy);
        mac_b    = ONE;
      end
      default: ;
    endcase
  end

  glos_mac #(.ACC_W(EW)) u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (walk_error)
  );

  // Bounds of the current walk cell
  logic [XW-1:0] wx_u, wy_u;
  logic          cur_inb;
  assign wx_u    = XW'($unsigned(walk_x));
  assign wy_u    = XW'($unsigned(walk_y));
  assign cur_inb = !walk_x[CW-1] && !walk_y[CW-1] &&
                   (wx_u < XW'(SIDE)) && (wy_u < XW'(SIDE));

  // Map access
  logic            map_rd_en, map_wr_en;
  logic [MSB-1:0]  map_rd_row, map_wr_row;
  logic [SIDE-1:0] map_rd_data, map_wr_data, row_mod;

  always_comb begin
    row_mod         = map_rd_data;
    row_mod[wr_col] = wr_open;
  end

  assign map_rd_en   = (state == ST_WR_RD) || (state == ST_WALK);
  assign map_rd_row  = (state == ST_WR_RD) ? wr_row_q : wy_u[MSB-1:0];
  assign map_wr_en   = (state == ST_CLEAR) || (state == ST_WR_WB);
  assign map_wr_row  = (state == ST_CLEAR) ? clr_row : wr_row_q;
  assign map_wr_data = (state == ST_CLEAR) ? '0 : row_mod;

  glos_map #(.SIDE_BITS(MSB)) u_map (
    .clk     (clk),
    .rd_en   (map_rd_en),
    .rd_row  (map_rd_row),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_row  (map_wr_row),
    .wr_data (map_wr_data)
  );

  // Check of the cell read in the previous cycle
  logic               chk_open;
  logic [COUNT_W-1:0] cnt_inc;
  assign chk_open = pend_inb && map_rd_data[pend_col];
  assign cnt_inc  = (cnt < COUNT_MAX) ? cnt + COUNT_W'(1) : cnt;

  assign s_axis_tready = (state == ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_row       <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // result taken; a new one from ST_DONE is handled there
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + MSB'(1);
          if (clr_row == {MSB{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc_in) begin
            if (s_axis_tuser == MODE_WRITE) begin
              wr_col   <= wx_ext[MSB-1:0];
              wr_row_q <= wy_ext[MSB-1:0];
              wr_open  <= in_cell_open;
              state    <= ST_WR_RD;
            end else begin
              dx         <= q_dx;
              dy         <= q_dy;
              fxa        <= q_fxa;
              fya        <= q_fya;
              xpos       <= q_xpos;
              ypos       <= q_ypos;
              walk_x     <= CW'(cx0);
              walk_y     <= CW'(cy0);
              steps_left <= q_steps;
              state      <= ST_MUL1;
            end
          end
        end
        ST_WR_RD: begin
          state <= ST_WR_WB;
        end
        ST_WR_WB: begin
          res_clear <= 1'b0;
          cnt       <= '0;
          state     <= ST_DONE;
        end
        ST_MUL1: begin
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          pend_valid <= 1'b0;
          cnt        <= '0;
          state      <= ST_WALK;
        end
        ST_WALK: begin
          // issue the read of the current cell and step on
          pend_valid <= steps_left != '0;
          pend_inb   <= cur_inb;
          pend_col   <= wx_u[MSB-1:0];
          pend_last  <= steps_left == SW'(1);
          if (steps_left != '0) begin
            steps_left <= steps_left - SW'(1);
            if (err_pos) begin
              walk_y <= ypos ? walk_y + CW'(1) : walk_y - CW'(1);
            end else begin
              walk_x <= xpos ? walk_x + CW'(1) : walk_x - CW'(1);
            end
          end
          // check the cell read last cycle
          if (pend_valid) begin
            cnt <= cnt_inc;
            if (!chk_open || pend_last) begin
              res_clear <= chk_open;
              state     <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= M_TDATA_W'({cnt, res_clear});
    end
  end

endmodule

// File: rtl/core/glos_checker.sv
// Port-level checks on the line-of-sight walk
module glos_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [glos_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [glos_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  import glos_pkg::*;

`include "grid_line_of_sight_walk_assert.svh"

  // A stalled result holds
  `GLOS_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

  // One item at a time: no second item straight after an accepted one
  `GLOS_ASSERT_NXT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // No result can appear in the cycle after an item is taken
  `GLOS_ASSERT_NXT(a_no_early, clk, rst, s_axis_tvalid && s_axis_tready,
                   !$rose(m_axis_tvalid))

  // A clear line has examined at least one cell
  `GLOS_ASSERT_IMP(a_clear_cnt, clk, rst, m_axis_tvalid && m_axis_tdata[0],
                   m_axis_tdata[COUNT_W:1] != '0)

endmodule

bind grid_line_of_sight_walk glos_checker u_glos_checker (.*);
